>>> src/hfsvg_pkg.sv
`timescale 1ns / 1ps
// Package for the HFS volume geometry and fork layout block.
// Payload structs, status and register codes, divider length, extents helper.
// No dependencies.
package hfsvg_pkg;

    // Sector and catalog limits
    localparam int SECTOR_SHIFT      = 9;
    localparam int MAX_CATALOG_NODES = 2048;
    localparam int VLEN_W            = 31 - SECTOR_SHIFT;   // whole sectors, 22 bits
    localparam int DIV_STEPS         = VLEN_W;              // one quotient bit per cycle
    localparam logic [23:0] SAT24    = 24'hFF_FFFF;

    // Status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_ALIGN    = 3'd1;
    localparam logic [2:0] STAT_SMALL    = 3'd2;
    localparam logic [2:0] STAT_TOO_MANY = 3'd3;
    localparam logic [2:0] STAT_NO_FIT   = 3'd4;

    // Register indexes (byte address 4*i)
    localparam logic [1:0] REG_VOLUME_BYTES  = 2'd0;
    localparam logic [1:0] REG_CATALOG_NODES = 2'd1;
    localparam logic [1:0] REG_TIGHT_PACKING = 2'd2;

    // Register reset values
    localparam logic [30:0] VOLUME_BYTES_RST  = 31'd819200;
    localparam logic [11:0] CATALOG_NODES_RST = 12'd32;

    typedef struct packed {
        logic [30:0] fork_bytes;
        logic        is_last;
    } t_fork_in;

    typedef struct packed {
        logic [15:0] start_block;
        logic [21:0] block_count;
        logic [6:0]  sectors_per_block;
        logic [4:0]  alloc_start_sector;
        logic [15:0] alloc_block_total;
        logic [23:0] used_blocks;
        logic [15:0] free_blocks;
        logic [2:0]  status;
        logic        done_res;
    } t_fork_res;

    // Extents tree blocks: ceil(8 / sectors per block), at least one
    function automatic logic [3:0] f_ext_blocks(input logic [6:0] lpa);
        logic [3:0] ext;
        case (lpa) inside
            7'd1:         ext = 4'd8;
            7'd2:         ext = 4'd4;
            7'd3:         ext = 4'd3;
            [7'd4:7'd7]:  ext = 4'd2;
            default:      ext = 4'd1;
        endcase
        return ext;
    endfunction

endpackage

>>> src/hfs_volume_geometry_and_fork_layout.sv
`timescale 1ns / 1ps
// Top level: volume geometry derivation and contiguous fork block layout.
// Depends on hfsvg_pkg; one shared restoring divider under a small sequencer.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------
//  fork in  | i_in_valid / o_in_stall     | i_in_data  (t_fork_in)
//  result   | o_out_valid / i_out_stall   | o_out_data (t_fork_res)
//  config   | APB psel/penable/pwrite     | paddr[3:2] index, pwdata
//
// A fork is accepted, then runs 22 divider steps (one quotient bit each, the
// 22-bit sector count over sectors per block), then is placed.
// After reset and after every register write the geometry is rederived in
// four passes of the divider; o_in_stall is high meanwhile.
// A finished result waits in the output register; the next fork may run,
// and its placement holds until that register is taken.
module hfs_volume_geometry_and_fork_layout
    import hfsvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_fork_in    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_fork_res   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {ST_GEO, ST_DIV, ST_POST, ST_IDLE} t_state;
    typedef enum logic [2:0] {OP_VBM, OP_ALLOC, OP_CAT, OP_FIFTH, OP_FORK} t_op;

    // Configuration registers
    logic [30:0] r_volume;
    logic [11:0] r_nodes;
    logic        r_tight;

    // Sequencer and divider
    t_state      r_state;
    t_op         r_op;
    logic [4:0]  r_cnt;
    logic [21:0] r_quo;
    logic [6:0]  r_rem;
    logic [6:0]  r_dvs;

    // Cached geometry
    logic [6:0]  r_lpa;
    logic [4:0]  r_alst;
    logic [15:0] r_total;
    logic [2:0]  r_err;
    logic [11:0] r_base;
    logic [13:0] r_fifth;

    // Layout state and the fork in flight
    logic [23:0] r_next;
    logic        r_first;
    logic        r_frac_nz;
    logic        r_bytes_nz;
    logic        r_last;

    // Output register
    logic        r_out_valid;
    t_fork_res   r_out_data;

    logic        cfg_wr;
    logic        cfg_hit;
    logic        in_acc;
    logic        slot_free;
    logic        out_load;
    logic [21:0] vlen;
    logic [6:0]  lpa_new;
    logic [7:0]  d_shift;
    logic        d_ge;
    logic [6:0]  n_rem;
    logic [21:0] n_quo;
    logic [22:0] vbm_sum;
    logic [11:0] alst_full;
    logic [2:0]  err_new;
    logic [21:0] alloc_dvd;
    logic [11:0] nodes_cl;
    logic [11:0] cat_ceil;
    logic [22:0] cnt_full;
    logic [23:0] cur;
    logic [24:0] run_sum;
    logic [23:0] nxt;
    logic [13:0] head;
    logic [24:0] need_sum;
    logic [15:0] free_blk;
    logic [2:0]  stat_res;

    assign cfg_wr     = psel && penable && pwrite;
    assign cfg_hit    = cfg_wr && (paddr[3:2] inside {REG_VOLUME_BYTES, REG_CATALOG_NODES,
                                                       REG_TIGHT_PACKING});
    assign pready     = 1'b1;
    assign o_in_stall = (r_state != ST_IDLE) || cfg_wr;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_POST) && (r_op == OP_FORK) && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            REG_VOLUME_BYTES:  prdata = {1'b0, r_volume};
            REG_CATALOG_NODES: prdata = {20'd0, r_nodes};
            REG_TIGHT_PACKING: prdata = {31'd0, r_tight};
            default:           prdata = 32'd0;
        endcase
    end

    // Sectors per block from whole sectors
    assign vlen    = r_volume[30:SECTOR_SHIFT];
    assign lpa_new = (vlen >= 22'd6) ? 7'd1 + 7'((vlen - 22'd6) >> 16) : 7'd1;

    // Restoring divider step
    assign d_shift = {r_rem, r_quo[21]};
    assign d_ge    = d_shift >= {1'b0, r_dvs};
    assign n_rem   = d_ge ? 7'(d_shift - {1'b0, r_dvs}) : d_shift[6:0];
    assign n_quo   = {r_quo[20:0], d_ge};

    // Geometry post-processing
    assign vbm_sum   = {1'b0, r_quo} + 23'h000FFF;
    assign alst_full = 12'd3 + {1'b0, vbm_sum[22:12]};
    assign alloc_dvd = vlen - 22'd2 - {10'd0, alst_full};
    always_comb begin
        if (r_volume[SECTOR_SHIFT-1:0] != '0)
            err_new = STAT_ALIGN;
        else if (vlen < 22'd100 ||
                 vlen < {10'd0, alst_full} + 22'd2 + {15'd0, r_lpa})
            err_new = STAT_SMALL;
        else
            err_new = STAT_OK;
    end
    assign nodes_cl = (r_nodes == 12'd0) ? 12'd1 :
                      (r_nodes > 12'(MAX_CATALOG_NODES)) ? 12'(MAX_CATALOG_NODES) : r_nodes;
    assign cat_ceil = r_quo[11:0] + {11'd0, r_rem != 7'd0};

    // Fork placement
    assign cnt_full = {1'b0, r_quo} + {22'd0, (r_rem != 7'd0) || r_frac_nz};
    assign cur      = r_first ? {12'd0, r_base} : r_next;
    assign run_sum  = {1'b0, cur} + {2'd0, cnt_full};
    assign nxt      = (run_sum > {1'b0, SAT24}) ? SAT24 : run_sum[23:0];
    assign head     = r_tight ? 14'd16 : r_fifth + 14'd4;
    assign need_sum = {1'b0, nxt} + {11'd0, head};
    assign free_blk = ({8'd0, r_total} > nxt) ? r_total - nxt[15:0] : 16'd0;
    always_comb begin
        stat_res = r_err;
        if (r_last && r_err == STAT_OK && need_sum > {9'd0, r_total})
            stat_res = STAT_NO_FIT;
    end

    // Sequencer, divider, cached geometry and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= VOLUME_BYTES_RST;
            r_nodes     <= CATALOG_NODES_RST;
            r_tight     <= 1'b1;
            r_state     <= ST_GEO;
            r_op        <= OP_VBM;
            r_cnt       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // output transaction: load a placed fork, or drop once taken
            if (out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;

            if (cfg_hit) begin
                // a register write restarts the geometry pass
                r_state <= ST_GEO;
            end else begin
                case (r_state)
                    ST_GEO: begin
                        r_lpa   <= lpa_new;
                        r_quo   <= vlen;
                        r_rem   <= '0;
                        r_dvs   <= lpa_new;
                        r_cnt   <= '0;
                        r_op    <= OP_VBM;
                        r_state <= ST_DIV;
                    end
                    ST_DIV: begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'(DIV_STEPS - 1))
                            r_state <= ST_POST;
                    end
                    ST_POST: begin
                        case (r_op)
                            OP_VBM: begin
                                r_alst  <= alst_full[4:0];
                                r_err   <= err_new;
                                r_quo   <= alloc_dvd;
                                r_rem   <= '0;
                                r_dvs   <= r_lpa;
                                r_cnt   <= '0;
                                r_op    <= OP_ALLOC;
                                r_state <= ST_DIV;
                            end
                            OP_ALLOC: begin
                                if (r_err != STAT_OK) begin
                                    r_total <= '0;
                                end else if (r_quo > 22'h00FFFF) begin
                                    r_err   <= STAT_TOO_MANY;
                                    r_total <= '0;
                                end else begin
                                    r_total <= r_quo[15:0];
                                end
                                r_quo   <= {10'd0, nodes_cl};
                                r_rem   <= '0;
                                r_dvs   <= r_lpa;
                                r_cnt   <= '0;
                                r_op    <= OP_CAT;
                                r_state <= ST_DIV;
                            end
                            OP_CAT: begin
                                r_base  <= {8'd0, f_ext_blocks(r_lpa)} + cat_ceil;
                                r_quo   <= {6'd0, r_total};
                                r_rem   <= '0;
                                r_dvs   <= 7'd5;
                                r_cnt   <= '0;
                                r_op    <= OP_FIFTH;
                                r_state <= ST_DIV;
                            end
                            OP_FIFTH: begin
                                r_fifth <= r_quo[13:0];
                                r_state <= ST_IDLE;
                            end
                            OP_FORK: begin
                                // hold until the output register is free
                                if (slot_free) begin
                                    r_out_data.start_block <= r_bytes_nz ? cur[15:0] : 16'd0;
                                    r_out_data.block_count <= cnt_full[21:0];
                                    r_out_data.sectors_per_block  <= r_lpa;
                                    r_out_data.alloc_start_sector <= r_alst;
                                    r_out_data.alloc_block_total  <= r_total;
                                    r_out_data.used_blocks <= nxt;
                                    r_out_data.free_blocks <= free_blk;
                                    r_out_data.status      <= stat_res;
                                    r_out_data.done_res    <= r_last;
                                    r_next  <= nxt;
                                    r_first <= r_last;
                                    r_state <= ST_IDLE;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                    ST_IDLE: begin
                        if (in_acc) begin
                            r_quo      <= i_in_data.fork_bytes[30:SECTOR_SHIFT];
                            r_rem      <= '0;
                            r_dvs      <= r_lpa;
                            r_cnt      <= '0;
                            r_frac_nz  <= i_in_data.fork_bytes[SECTOR_SHIFT-1:0] != '0;
                            r_bytes_nz <= i_in_data.fork_bytes != '0;
                            r_last     <= i_in_data.is_last;
                            r_op       <= OP_FORK;
                            r_state    <= ST_DIV;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end

            // Register write: store the new value
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_VOLUME_BYTES:  r_volume <= pwdata[30:0];
                    REG_CATALOG_NODES: r_nodes  <= pwdata[11:0];
                    REG_TIGHT_PACKING: r_tight  <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // Checks
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_dvs)
        else $error("divider remainder not below divisor");

    a_lpa_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> (r_lpa != 7'd0 && r_lpa <= 7'd64))
        else $error("sectors per block out of range");

    a_nofit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STAT_NO_FIT) |-> o_out_data.done_res)
        else $error("fit verdict on a fork that is not the last");

    a_total_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_err != STAT_OK) |-> r_total == 16'd0)
        else $error("block total nonzero with a geometry error");

endmodule

>>> test/tb_hfs_volume_geometry_and_fork_layout.sv
`timescale 1ns / 1ps
// Testbench for hfs_volume_geometry_and_fork_layout: a directed stimulus table, then random
// volumes in phases of sender idling and receiver stalls, checked against a layout predictor.
// Depends on hfsvg_pkg and the block itself.
module tb_hfs_volume_geometry_and_fork_layout;
    import hfsvg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_FORKS    = 90;
    localparam int NUM_PHASES     = 12;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Block ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_fork_in    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_fork_res   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Registers and running state as the predictor sees them
    logic [30:0] vol_bytes;
    logic [11:0] cat_nodes;
    logic        tight;
    int unsigned lpa, alst, blk_total, next_block;
    logic [2:0]  geom_err;
    bit          first_pending;

    t_fork_res   expected_layouts[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] value;
        t_fork_in    item;
        bit          typed;
        t_fork_res   want;
    } t_stim_row;

    t_stim_row stim_rows[$];

    always #2 i_clk = ~i_clk;

    hfs_volume_geometry_and_fork_layout dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Geometry from the volume size: sectors per block, bitmap, block total, error
    task automatic rederive_volume();
        int unsigned sectors, bitmap;
        sectors  = int'(vol_bytes) >> SECTOR_SHIFT;
        lpa      = (sectors >= 6) ? 1 + ((sectors - 6) >> 16) : 1;
        bitmap   = ((sectors / lpa) + 32'h0fff) >> 12;
        alst     = 3 + bitmap;
        blk_total = 0;
        geom_err = STAT_OK;
        if (vol_bytes[8:0] != 0) begin
            geom_err = STAT_ALIGN;
        end else if (sectors < 100 || sectors < alst + 2 + lpa) begin
            geom_err = STAT_SMALL;
        end else if ((sectors - 2 - alst) / lpa > 32'hFFFF) begin
            geom_err = STAT_TOO_MANY;
        end else begin
            blk_total = (sectors - 2 - alst) / lpa;
        end
    endtask

    // Extents tree plus catalog tree blocks, node count clamped to its range
    function automatic int unsigned tree_blocks();
        int unsigned nodes;
        nodes = cat_nodes;
        if (nodes < 1) nodes = 1;
        if (nodes > MAX_CATALOG_NODES) nodes = MAX_CATALOG_NODES;
        return (8 + lpa - 1) / lpa + (nodes + lpa - 1) / lpa;
    endfunction

    // Place one fork and work out the result it should give
    task automatic place_fork(input t_fork_in item, output t_fork_res res);
        int unsigned blk, cnt, head;
        logic [2:0]  st;
        cnt = 0;
        res = '0;
        if (first_pending) begin
            next_block    = tree_blocks();
            first_pending = 0;
        end
        blk = lpa * 512;
        if (item.fork_bytes != 0) begin
            cnt = (int'(item.fork_bytes) + blk - 1) / blk;
            res.start_block = 16'(next_block);
            next_block = (next_block + cnt > 32'(SAT24)) ? 32'(SAT24) : next_block + cnt;
        end
        st = geom_err;
        // fit is judged on the last fork only
        if (item.is_last) begin
            if (st == STAT_OK) begin
                head = tight ? 16 : blk_total / 5 + 4;
                if (longint'(next_block) + head > longint'(blk_total)) st = STAT_NO_FIT;
            end
            first_pending = 1;
        end
        res.block_count        = 22'(cnt);
        res.sectors_per_block  = 7'(lpa);
        res.alloc_start_sector = 5'(alst);
        res.alloc_block_total  = 16'(blk_total);
        res.used_blocks        = 24'(next_block);
        res.free_blocks        = (blk_total > next_block) ? 16'(blk_total - next_block) : 16'd0;
        res.status             = st;
        res.done_res           = item.is_last;
    endtask

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got) note_mismatch(what, want, got);
    endtask

    // Offer one fork transaction, with random idle cycles ahead of it
    task automatic send_fork(input t_fork_in item, input bit typed, input t_fork_res want);
        t_fork_res predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        place_fork(item, predicted);
        expected_layouts.insert(expected_layouts.size(), typed ? want : predicted);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_layouts.size() != 0) @(posedge i_clk);
    endtask

    // APB write, read back, then wait out the geometry pass
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_VOLUME_BYTES:  vol_bytes = value[30:0];
            REG_CATALOG_NODES: cat_nodes = value[11:0];
            REG_TIGHT_PACKING: tight     = value[0];
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            rederive_volume();
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            case (idx)
                REG_VOLUME_BYTES:  want = {1'b0, vol_bytes};
                REG_CATALOG_NODES: want = {20'd0, cat_nodes};
                default:           want = {31'd0, tight};
            endcase
            check_field("register readback", want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic logic [30:0] random_fork_bytes();
        int unsigned mode, blk;
        mode = $urandom_range(0, 15);
        blk  = lpa * 512;
        case (mode)
            0:       return '0;
            1:       return 31'($urandom());
            2:       return 31'(blk * $urandom_range(1, 64));
            default: return 31'($urandom_range(0,
                         int'(vol_bytes) / ($urandom_range(0, 1) ? 6 : 96) + 1024));
        endcase
    endfunction

    function automatic logic [31:0] random_volume_bytes();
        case ($urandom_range(0, 9))
            0:       return {1'b0, 31'($urandom())};
            1:       return 32'h7FFF_FE00;
            2:       return 32'd2130706432;
            3:       return $urandom_range(0, 99) * 512;
            4, 5, 6: return $urandom_range(100, 16384) * 512;
            default: return $urandom_range(100, 4194303) * 512;
        endcase
    endfunction

    function automatic logic [31:0] random_catalog_nodes();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd4095;
            2:       return 32'd2048;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    task automatic row_cfg(input logic [1:0] idx, input logic [31:0] value);
        t_stim_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = value;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    task automatic row_fork(input logic [30:0] bytes, input logic last);
        t_stim_row r;
        r      = '{default: '0};
        r.item = {bytes, last};
        stim_rows.insert(stim_rows.size(), r);
    endtask

    task automatic row_typed(input logic [30:0] bytes, input logic last, input t_fork_res want);
        t_stim_row r;
        r       = '{default: '0};
        r.item  = {bytes, last};
        r.typed = 1'b1;
        r.want  = want;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // Receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Result checker: oldest expectation against each accepted result transaction
    always @(posedge i_clk) begin
        t_fork_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_layouts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result %h with none expected", $time, o_out_data);
            end else begin
                want = expected_layouts.pop_front();
                check_field("start_block", want.start_block, o_out_data.start_block);
                check_field("block_count", want.block_count, o_out_data.block_count);
                check_field("sectors_per_block", want.sectors_per_block,
                            o_out_data.sectors_per_block);
                check_field("alloc_start_sector", want.alloc_start_sector,
                            o_out_data.alloc_start_sector);
                check_field("alloc_block_total", want.alloc_block_total,
                            o_out_data.alloc_block_total);
                check_field("used_blocks", want.used_blocks, o_out_data.used_blocks);
                check_field("free_blocks", want.free_blocks, o_out_data.free_blocks);
                check_field("status", want.status, o_out_data.status);
                check_field("done_res", want.done_res, o_out_data.done_res);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_fork_in item;
        int       n_forks, sent;

        // predictor state after reset
        vol_bytes     = VOLUME_BYTES_RST;
        cat_nodes     = CATALOG_NODES_RST;
        tight         = 1'b1;
        rederive_volume();
        next_block    = tree_blocks();
        first_pending = 1;

        // Directed: reset geometry is 1594 blocks of one sector, 40 for the trees
        row_typed(31'd0, 1'b0,
            {16'd0, 22'd0, 7'd1, 5'd4, 16'd1594, 24'd40, 16'd1554, STAT_OK, 1'b0});
        row_typed(31'd1, 1'b0,
            {16'd40, 22'd1, 7'd1, 5'd4, 16'd1594, 24'd41, 16'd1553, STAT_OK, 1'b0});
        row_typed(31'd512, 1'b0,
            {16'd41, 22'd1, 7'd1, 5'd4, 16'd1594, 24'd42, 16'd1552, STAT_OK, 1'b0});
        row_typed(31'd513, 1'b1,
            {16'd42, 22'd2, 7'd1, 5'd4, 16'd1594, 24'd44, 16'd1550, STAT_OK, 1'b1});
        row_typed(31'd2130706432, 1'b1,
            {16'd40, 22'd4161536, 7'd1, 5'd4, 16'd1594, 24'd4161576, 16'd0,
             STAT_NO_FIT, 1'b1});
        // all-ones forks: count wraps in 22 bits, running total saturates
        repeat (5) row_fork(31'h7FFF_FFFF, 1'b0);
        row_fork(31'd0, 1'b1);
        row_cfg(REG_TIGHT_PACKING, 32'd0);
        row_fork(31'd1000, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'd819201);
        row_typed(31'd0, 1'b1,
            {16'd0, 22'd0, 7'd1, 5'd4, 16'd0, 24'd40, 16'd0, STAT_ALIGN, 1'b1});
        row_cfg(REG_VOLUME_BYTES, 32'd0);
        row_typed(31'd0, 1'b1,
            {16'd0, 22'd0, 7'd1, 5'd3, 16'd0, 24'd40, 16'd0, STAT_SMALL, 1'b1});
        row_cfg(REG_VOLUME_BYTES, 32'd2560);
        row_fork(31'd5000, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'd50688);
        row_fork(31'd100, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'd51200);
        row_cfg(REG_CATALOG_NODES, 32'd0);
        row_fork(31'd20480, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'd2130706432);
        row_cfg(REG_CATALOG_NODES, 32'd4095);
        row_fork(31'd2130706432, 1'b0);
        row_fork(31'd1, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'h7FFF_FE00);
        row_cfg(REG_CATALOG_NODES, 32'd2048);
        row_cfg(REG_TIGHT_PACKING, 32'd1);
        row_fork(31'd12345, 1'b1);
        row_cfg(REG_VOLUME_BYTES, 32'h7FFF_FFFF);
        row_fork(31'd777, 1'b1);
        // a write past the register list must change nothing
        row_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        row_fork(31'd0, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                wait_drained();
                cfg_write(stim_rows[i].idx, stim_rows[i].value);
            end else begin
                send_fork(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Random volumes; each phase gets fresh settings and its own idling mode
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            cfg_write(REG_VOLUME_BYTES, random_volume_bytes());
            cfg_write(REG_CATALOG_NODES, random_catalog_nodes());
            cfg_write(REG_TIGHT_PACKING, $urandom_range(0, 1));
            sent = 0;
            while (sent < PHASE_FORKS) begin
                n_forks = $urandom_range(1, 10);
                for (int k = 0; k < n_forks; k++) begin
                    item.fork_bytes = random_fork_bytes();
                    item.is_last    = (k == n_forks - 1);
                    send_fork(item, 1'b0, '0);
                end
                sent += n_forks;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
